// File: src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and constants of the row lock table: default sizes, register
// map, command codes, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // default table depth and row number width
  localparam int ENTRIES_DEF  = 16;
  localparam int ROW_BITS_DEF = 30;

  // register map
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_EXCLUSIVE_OPEN = 2'd0;

  // command codes
  localparam logic CMD_UNLOCK = 1'b0;
  localparam logic CMD_LOCK   = 1'b1;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_BAD_FILE   = 3'd1;
  localparam status_t ST_BAD_ARG    = 3'd2;
  localparam status_t ST_NOT_TRANS  = 3'd3;
  localparam status_t ST_TABLE_FULL = 3'd4;

  // scan sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_CMP  = 3'b100
  } state_t;

endpackage

// File: src/rlt_ram.sv
// ----------------------------------------------------------------------------
// rlt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/row_lock_table.sv
// ----------------------------------------------------------------------------
// row_lock_table
// Bounded table of held row locks. A single row comparator walks the table
// entry by entry (read, then compare and act) to find the row and the lowest
// free slot; whole-file requests clear all valid bits at once.
// Exclusive, whole-file and refused requests get their result in the cycle
// after the transfer; row requests wait on the entry scan through the row
// RAM's single read port, which stops at a hit.
// Throughput: one request at a time; the next transfer is taken once the
//   result has been taken.
// Reset: rst_n synchronous active low; table empty, data-locked flag and
//   exclusive_open cleared. No clearing pass.
// ----------------------------------------------------------------------------
module row_lock_table #(
  parameter int ENTRIES  = rlt_pkg::ENTRIES_DEF,
  parameter int ROW_BITS = rlt_pkg::ROW_BITS_DEF,
  parameter int DATA_W   = ((ROW_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input requests
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [DATA_W-1:0]               in_tdata,   // [ROW_BITS-1:0] row_number
  input  logic [2:0]                      in_tuser,   // [0] command, [1] transactional,
                                                      // [2] range_lock_refused
  // results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [2:0] status
  output logic                            out_tuser,  // [0] file_data_locked
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rlt_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  import rlt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic                trans;
  } entry_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic                cmd_r, cmd_nxt;
  logic                trans_r, trans_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic                locked_r, locked_nxt;
  logic                excl_r;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_locked_r, out_locked_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;

  logic                in_xfer;
  logic                cfg_wr;
  logic [ROW_BITS-1:0] in_row;
  logic                cur_valid;
  logic                hit;
  logic                free_now;
  logic [IDX_W-1:0]    free_slot;

  // row and mark storage
  rlt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES),
    .ADDR_W(IDX_W)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  // handshakes
  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_xfer    = in_tvalid && in_tready;
  assign in_row     = in_tdata[ROW_BITS-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r};
  assign out_tuser  = out_locked_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == REG_EXCLUSIVE_OPEN);
  assign cfg_prdata = (cfg_paddr == REG_EXCLUSIVE_OPEN) ? {31'd0, excl_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r <= 1'b0;
    end else if (cfg_wr) begin
      excl_r <= cfg_pwdata[0];
    end
  end

  // compare of the entry read last cycle
  assign cur_valid = valid_r[idx_r];
  assign hit       = cur_valid && (ram_rdata.row == row_r);
  assign free_now  = free_found_r || !cur_valid;
  assign free_slot = free_found_r ? free_idx_r : idx_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    row_nxt         = row_r;
    cmd_nxt         = cmd_r;
    trans_nxt       = trans_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    valid_nxt       = valid_r;
    locked_nxt      = locked_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_locked_nxt  = out_locked_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata.row   = row_r;
    ram_wdata.trans = trans_r;

    // drop the result once transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          row_nxt        = in_row;
          cmd_nxt        = in_tuser[0];
          trans_nxt      = in_tuser[1];
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          if (excl_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_locked_nxt = locked_r;
          end else if (in_row == '0) begin
            // whole-file request: empty the table, set or clear the flag
            valid_nxt      = '0;
            locked_nxt     = in_tuser[0];
            out_valid_nxt  = 1'b1;
            out_status_nxt = in_tuser[2] ? ST_BAD_FILE : ST_OK;
            out_locked_nxt = in_tuser[0];
          end else if (in_tuser[2]) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BAD_FILE;
            out_locked_nxt = locked_r;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        // track lowest free slot
        if (!free_found_r && !cur_valid) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        out_locked_nxt = locked_r;
        if (hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_LOCK) begin
            // rewrite the mark of the held row
            ram_we         = 1'b1;
            out_status_nxt = ST_OK;
          end else if (ram_rdata.trans && !trans_r) begin
            out_status_nxt = ST_NOT_TRANS;
          end else begin
            valid_nxt[idx_r] = 1'b0;
            out_status_nxt   = ST_OK;
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_UNLOCK) begin
            out_status_nxt = ST_BAD_ARG;
          end else if (free_now) begin
            // add a new entry in the lowest free slot
            ram_we               = 1'b1;
            ram_waddr            = free_slot;
            valid_nxt[free_slot] = 1'b1;
            out_status_nxt       = ST_OK;
          end else begin
            out_status_nxt = ST_TABLE_FULL;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      locked_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      locked_r    <= locked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    row_r        <= row_nxt;
    cmd_r        <= cmd_nxt;
    trans_r      <= trans_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_locked_r <= out_locked_nxt;
  end

endmodule
